### sv/lbmt_pkg.sv
// Shared types, codes and helpers for the learning bridge MAC table.
package lbmt_pkg;

    typedef enum logic [1:0] {
        ACT_UNICAST = 2'd0,
        ACT_FLOOD   = 2'd1,
        ACT_ABORT   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_LEARN,
        BS_LOOK
    } t_bstate;

    localparam int MAC_GROUP_BIT = 40;

    typedef struct packed {
        logic        abort;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [7:0]  in_port;
    } t_job;

    typedef struct packed {
        t_action     action;
        logic [7:0]  egress_port;
    } t_result;

    // XOR of the six address bytes
    function automatic logic [7:0] mac_fold(logic [47:0] mac);
        logic [7:0] x;
        x = '0;
        for (int i = 0; i < 6; i++) begin
            x = x ^ mac[8*i +: 8];
        end
        return x;
    endfunction

endpackage

### sv/lbmt_fifo.sv
// Two-entry queue used between the front and the engine and on the result side.
module lbmt_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### sv/lbmt_front.sv
// Front end: classifies a frame and works out the set index of both addresses.
module lbmt_front #(
    parameter int PORT_COUNT = 256,
    parameter int SETS       = 256,
    parameter int SW         = 8
) (
    input  logic                i_header_ok,
    input  logic [47:0]         i_src_mac,
    input  logic [47:0]         i_dst_mac,
    input  logic [7:0]          i_in_port,
    output lbmt_pkg::t_job      o_job,
    output logic [SW-1:0]       o_src_set,
    output logic [SW-1:0]       o_dst_set
);
    import lbmt_pkg::*;

    // folded byte reduced modulo the set count by restoring subtraction
    function automatic logic [SW-1:0] set_of(logic [47:0] mac);
        logic [31:0] rem;
        rem = 32'(mac_fold(mac));
        if (SETS < 256) begin
            for (int k = 7; k >= 0; k--) begin
                if (rem >= (32'(SETS) << k)) begin
                    rem = rem - (32'(SETS) << k);
                end
            end
        end
        return SW'(rem);
    endfunction

    always_comb begin
        o_job.abort   = !i_header_ok || ({1'b0, i_in_port} >= 9'(PORT_COUNT));
        o_job.src_mac = i_src_mac;
        o_job.dst_mac = i_dst_mac;
        o_job.in_port = i_in_port;
        o_src_set     = set_of(i_src_mac);
        o_dst_set     = set_of(i_dst_mac);
    end

endmodule

### sv/lbmt_engine.sv
// Back end: table memory with learn and lookup read-modify-write sequencing.
module lbmt_engine #(
    parameter int WAYS = 4,
    parameter int SETS = 256,
    parameter int SW   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_empty,
    input  lbmt_pkg::t_job     i_job,
    input  logic [SW-1:0]      i_job_src_set,
    input  logic [SW-1:0]      i_job_dst_set,
    output logic               o_job_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output lbmt_pkg::t_result  o_res,
    output logic               o_clearing
);
    import lbmt_pkg::*;

    localparam int AW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WW = AW;
    localparam logic [AW-1:0] AGE_MAX  = AW'(WAYS - 1);
    localparam logic [SW-1:0] CLR_LAST = SW'(SETS - 1);

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] age;
        logic [47:0]   mac;
        logic [7:0]    port;
    } t_ent;
    typedef t_ent [WAYS-1:0]          t_row;
    typedef logic [WAYS-1:0][AW-1:0]  t_ages;

    t_row          r_table [SETS];
    t_row          r_rd_row;
    t_row          r_lrow;
    t_bstate       r_state;
    t_bstate       n_state;
    logic [SW-1:0] r_clr;
    t_job          r_job;
    logic [SW-1:0] r_src_set;
    logic [SW-1:0] r_dst_set;

    logic [SW-1:0] rd_addr;
    logic [SW-1:0] wr_addr;
    logic          wr_en;
    t_row          wr_row;
    logic          take;

    // learn path
    logic [WW-1:0] l_hit_way;
    logic [WW-1:0] l_free_way;
    logic [WW-1:0] l_vic_way;
    logic [WW-1:0] l_way;
    logic          l_hit_any;
    logic          l_free_any;
    logic [AW-1:0] l_best;
    t_ages         l_ages;
    t_row          l_row;

    // lookup path
    t_row          k_in;
    logic [WW-1:0] k_way;
    logic          k_hit;
    t_ages         k_ages;
    t_row          k_row;
    t_result       k_res;

    function automatic t_ages ages_of(t_row row);
        t_ages a;
        for (int w = 0; w < WAYS; w++) begin
            a[w] = row[w].age;
        end
        return a;
    endfunction

    // touched way goes to rank 0; ranks at or below its old rank age by one
    function automatic t_ages touch(t_ages a, logic [WW-1:0] way);
        t_ages         r;
        logic [AW-1:0] rk;
        r  = a;
        rk = a[way];
        for (int v = 0; v < WAYS; v++) begin
            if (WW'(v) != way && a[v] <= rk && a[v] < AGE_MAX) begin
                r[v] = a[v] + 1'b1;
            end
        end
        r[way] = '0;
        return r;
    endfunction

    assign take = (r_state == BS_IDLE) && !i_job_empty && !i_res_full;

    always_comb begin
        l_hit_way  = '0;
        l_hit_any  = 1'b0;
        l_free_way = '0;
        l_free_any = 1'b0;
        l_vic_way  = '0;
        l_best     = r_rd_row[0].age;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rd_row[w].valid && r_rd_row[w].mac == r_job.src_mac) begin
                l_hit_way = WW'(w);
                l_hit_any = 1'b1;
            end
            if (!r_rd_row[w].valid) begin
                l_free_way = WW'(w);
                l_free_any = 1'b1;
            end
        end
        // oldest way, lowest index on a tie
        for (int w = 1; w < WAYS; w++) begin
            if (r_rd_row[w].age > l_best) begin
                l_best    = r_rd_row[w].age;
                l_vic_way = WW'(w);
            end
        end
        if (l_hit_any) begin
            l_way = l_hit_way;
        end else if (l_free_any) begin
            l_way = l_free_way;
        end else begin
            l_way = l_vic_way;
        end
        l_ages = touch(ages_of(r_rd_row), l_way);
        l_row  = r_rd_row;
        for (int w = 0; w < WAYS; w++) begin
            l_row[w].age = l_ages[w];
        end
        l_row[l_way].valid = 1'b1;
        l_row[l_way].mac   = r_job.src_mac;
        l_row[l_way].port  = r_job.in_port;
    end

    always_comb begin
        // same set as the learn written last cycle: take the fresh row
        k_in  = (r_dst_set == r_src_set) ? r_lrow : r_rd_row;
        k_way = '0;
        k_hit = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (k_in[w].valid && k_in[w].mac == r_job.dst_mac) begin
                k_way = WW'(w);
                k_hit = 1'b1;
            end
        end
        k_ages = touch(ages_of(k_in), k_way);
        k_row  = k_in;
        for (int w = 0; w < WAYS; w++) begin
            k_row[w].age = k_ages[w];
        end
        if (k_hit && !r_job.dst_mac[MAC_GROUP_BIT]) begin
            k_res.action      = ACT_UNICAST;
            k_res.egress_port = k_in[k_way].port;
        end else begin
            k_res.action      = ACT_FLOOD;
            k_res.egress_port = 8'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (take && !i_job.abort) begin
                    n_state = BS_LEARN;
                end
            end
            BS_LEARN: n_state = BS_LOOK;
            BS_LOOK:  n_state = BS_IDLE;
            default:  n_state = BS_CLEAR;
        endcase
    end

    always_comb begin
        o_job_pop         = 1'b0;
        o_res_push        = 1'b0;
        o_res.action      = ACT_ABORT;
        o_res.egress_port = 8'd0;
        o_clearing        = 1'b0;
        rd_addr           = r_dst_set;
        wr_addr           = r_src_set;
        wr_en             = 1'b0;
        wr_row            = l_row;
        case (r_state)
            BS_CLEAR: begin
                o_clearing = 1'b1;
                wr_en      = 1'b1;
                wr_addr    = r_clr;
                wr_row     = '0;
            end
            BS_IDLE: begin
                o_job_pop  = take;
                o_res_push = take && i_job.abort;
                rd_addr    = i_job_src_set;
            end
            BS_LEARN: begin
                wr_en   = 1'b1;
                wr_addr = r_src_set;
                wr_row  = l_row;
                rd_addr = r_dst_set;
            end
            BS_LOOK: begin
                wr_en      = k_hit;
                wr_addr    = r_dst_set;
                wr_row     = k_row;
                o_res_push = 1'b1;
                o_res      = k_res;
            end
            default: begin
                o_clearing = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job     <= i_job;
            r_src_set <= i_job_src_set;
            r_dst_set <= i_job_dst_set;
        end
        if (r_state == BS_LEARN) begin
            r_lrow <= l_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_row;
        end
        r_rd_row <= r_table[rd_addr];
    end

endmodule

### sv/learning_bridge_mac_table_core.sv
// Top level of the learning bridge MAC table: front, job queue, engine, result queue.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  frames   | push / full        | i_header_ok, i_src_mac, i_dst_mac, i_in_port
//  results  | pop / empty        | o_action, o_egress_port
//
// A good frame goes through the engine steps source set read, learn write with
// destination read, lookup write. These are read-modify-writes on the table row
// memory, which has one read and one write port. A bad header or out-of-range
// port gets its abort result straight from the idle state.
// After reset a clearing pass writes every set (TABLE_ENTRIES/WAYS of them,
// 256 by default), with full held high.
// Two-entry queues on both sides let input and output stall independently.
module learning_bridge_mac_table_core #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int WAYS          = 4,
    parameter int PORT_COUNT    = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic              i_header_ok,
    input  logic [47:0]       i_src_mac,
    input  logic [47:0]       i_dst_mac,
    input  logic [7:0]        i_in_port,
    input  logic              pop,
    output logic              empty,
    output lbmt_pkg::t_action o_action,
    output logic [7:0]        o_egress_port
);
    import lbmt_pkg::*;

    localparam int SETS = TABLE_ENTRIES / WAYS;
    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int JW   = $bits(t_job) + 2 * SW;
    localparam int RW   = $bits(t_result);

    t_job          f_job;
    logic [SW-1:0] f_src_set;
    logic [SW-1:0] f_dst_set;
    logic [JW-1:0] q_wdata;
    logic [JW-1:0] q_rdata;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    t_job          e_job;
    logic [SW-1:0] e_src_set;
    logic [SW-1:0] e_dst_set;
    logic          clearing;
    logic          res_push;
    logic          res_full;
    t_result       res_in;
    t_result       res_out;
    logic [RW-1:0] res_rdata;

    assign full = q_full || clearing;

    lbmt_front #(
        .PORT_COUNT (PORT_COUNT),
        .SETS       (SETS),
        .SW         (SW)
    ) u_front (
        .i_header_ok (i_header_ok),
        .i_src_mac   (i_src_mac),
        .i_dst_mac   (i_dst_mac),
        .i_in_port   (i_in_port),
        .o_job       (f_job),
        .o_src_set   (f_src_set),
        .o_dst_set   (f_dst_set)
    );

    assign q_wdata = {f_src_set, f_dst_set, f_job};
    assign {e_src_set, e_dst_set, e_job} = q_rdata;

    lbmt_fifo #(
        .WIDTH (JW)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    lbmt_engine #(
        .WAYS (WAYS),
        .SETS (SETS),
        .SW   (SW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (q_empty),
        .i_job         (e_job),
        .i_job_src_set (e_src_set),
        .i_job_dst_set (e_dst_set),
        .o_job_pop     (q_pop),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res_in),
        .o_clearing    (clearing)
    );

    lbmt_fifo #(
        .WIDTH (RW)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_rdata)
    );

    assign res_out       = t_result'(res_rdata);
    assign o_action      = res_out.action;
    assign o_egress_port = res_out.egress_port;

endmodule

### sv/lbmt_checker.sv
// Port-level checks for the MAC table top level, bound to it below.
module lbmt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              pop,
    input logic              empty,
    input lbmt_pkg::t_action o_action,
    input logic [7:0]        o_egress_port
);
    import lbmt_pkg::*;

    logic r_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b1;
        end
    end

    a_empty_after_reset: assert property (@(posedge i_clk)
        r_armed == 1'b1 && $rose(i_rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_port_zero_unless_unicast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed == 1'b1 && !empty && o_action != ACT_UNICAST |-> o_egress_port == 8'd0)
        else $error("flood or abort item carries a port");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed == 1'b1 && !empty && !pop
        |=> !empty && $stable(o_action) && $stable(o_egress_port))
        else $error("waiting result changed");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed == 1'b1 && $rose(full) && $past(i_rst_n) |-> $past(push))
        else $error("input side filled without a push");

endmodule

bind learning_bridge_mac_table_core lbmt_checker u_lbmt_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the learning bridge MAC table: queued frames, predictor, checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lbmt_pkg::*;

    localparam int TABLE_ENTRIES = 1024;
    localparam int WAYS          = 4;
    localparam int SETS          = TABLE_ENTRIES / WAYS;
    localparam int PORT_COUNT    = 256;
    localparam int RANDOM_FRAMES = 830;
    localparam int POOL_SIZE     = 48;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        bit        hdr_ok;
        bit [47:0] src;
        bit [47:0] dst;
        bit [7:0]  port;
    } t_frame;

    typedef struct {
        t_action  act;
        bit [7:0] egress;
    } t_verdict;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        pop           = 1'b0;
    logic        i_header_ok   = 1'b0;
    logic [47:0] i_src_mac     = '0;
    logic [47:0] i_dst_mac     = '0;
    logic [7:0]  i_in_port     = '0;
    logic        full;
    logic        empty;
    t_action     o_action;
    logic [7:0]  o_egress_port;

    t_frame      pending_frames[$];
    t_verdict    expected_verdicts[$];
    bit          frame_taken;
    int unsigned total_frames;
    int unsigned frames_taken;
    int unsigned results_seen;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // predictor copy of the MAC table
    bit          tbl_valid[TABLE_ENTRIES];
    bit [47:0]   tbl_mac[TABLE_ENTRIES];
    bit [7:0]    tbl_port[TABLE_ENTRIES];
    int unsigned tbl_rank[TABLE_ENTRIES];

    learning_bridge_mac_table_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_header_ok   (i_header_ok),
        .i_src_mac     (i_src_mac),
        .i_dst_mac     (i_dst_mac),
        .i_in_port     (i_in_port),
        .pop           (pop),
        .empty         (empty),
        .o_action      (o_action),
        .o_egress_port (o_egress_port)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned set_index(bit [47:0] mac);
        bit [7:0] folded;
        folded = mac[47:40] ^ mac[39:32] ^ mac[31:24] ^ mac[23:16] ^ mac[15:8] ^ mac[7:0];
        return folded % SETS;
    endfunction

    function automatic int find_way(int unsigned set, bit [47:0] mac);
        for (int w = 0; w < WAYS; w++) begin
            if (tbl_valid[set*WAYS + w] && tbl_mac[set*WAYS + w] == mac)
                return w;
        end
        return -1;
    endfunction

    // touched way goes to rank 0, younger-or-equal ways age by one
    function automatic void refresh_way(int unsigned set, int unsigned way);
        int unsigned base;
        int unsigned r;
        base = set * WAYS;
        r    = tbl_rank[base + way];
        for (int unsigned v = 0; v < WAYS; v++) begin
            if (v != way && tbl_rank[base + v] <= r && tbl_rank[base + v] < WAYS - 1)
                tbl_rank[base + v]++;
        end
        tbl_rank[base + way] = 0;
    endfunction

    function automatic void learn_source(bit [47:0] mac, bit [7:0] port);
        int unsigned set;
        int unsigned base;
        int          hit;
        int unsigned way;
        bit          free_found;
        int unsigned oldest;
        set        = set_index(mac);
        base       = set * WAYS;
        hit        = find_way(set, mac);
        way        = 0;
        free_found = 1'b0;
        if (hit >= 0) begin
            way = hit;
        end else begin
            for (int unsigned w = 0; w < WAYS; w++) begin
                if (!free_found && !tbl_valid[base + w]) begin
                    way        = w;
                    free_found = 1'b1;
                end
            end
            if (!free_found) begin
                // victim is the oldest way, lowest index on a tie
                oldest = tbl_rank[base];
                for (int unsigned w = 1; w < WAYS; w++) begin
                    if (tbl_rank[base + w] > oldest) begin
                        oldest = tbl_rank[base + w];
                        way    = w;
                    end
                end
            end
        end
        tbl_valid[base + way] = 1'b1;
        tbl_mac[base + way]   = mac;
        tbl_port[base + way]  = port;
        refresh_way(set, way);
    endfunction

    function automatic t_verdict forward_frame(t_frame f);
        t_verdict    v;
        int unsigned set;
        int          hit;
        v.act    = ACT_ABORT;
        v.egress = '0;
        if (!f.hdr_ok || f.port >= PORT_COUNT)
            return v;
        learn_source(f.src, f.port);
        set = set_index(f.dst);
        hit = find_way(set, f.dst);
        if (hit >= 0)
            refresh_way(set, hit);
        if (hit < 0 || f.dst[MAC_GROUP_BIT]) begin
            v.act = ACT_FLOOD;
        end else begin
            v.act    = ACT_UNICAST;
            v.egress = tbl_port[set*WAYS + hit];
        end
        return v;
    endfunction

    function automatic bit [47:0] rand_mac();
        bit [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // random address whose byte fold lands in the given set
    function automatic bit [47:0] mac_in_set(bit [7:0] set);
        bit [47:0] m;
        m       = rand_mac();
        m[7:0]  = '0;
        m[7:0]  = 8'(set_index(m)) ^ set;
        return m;
    endfunction

    function automatic bit [47:0] evict_mac(bit [7:0] k);
        return {k, k, 8'h5a, 24'h0};
    endfunction

    task automatic add_frame(bit ok, bit [47:0] src, bit [47:0] dst, bit [7:0] port);
        t_frame f;
        f.hdr_ok = ok;
        f.src    = src;
        f.dst    = dst;
        f.port   = port;
        pending_frames.push_back(f);
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int unsigned load_phase(int unsigned count);
        int unsigned p;
        p = (total_frames == 0) ? 0 : count * 4 / total_frames;
        return (p > 3) ? 3 : p;
    endfunction

    function automatic int unsigned sender_idle_pct();
        case (load_phase(frames_taken))
            1:       return 50;
            3:       return 18;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct();
        case (load_phase(results_seen))
            2:       return 50;
            3:       return 18;
            default: return 0;
        endcase
    endfunction

    // acceptance of frames and checking of results
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            frame_taken = push && !full;
            if (frame_taken) begin
                frames_taken++;
                expected_verdicts.push_back(forward_frame(pending_frames.pop_front()));
            end
            if (pop && !empty) begin
                results_seen++;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected item: action %0d egress %0d",
                                              o_action, o_egress_port));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_action !== want.act)
                        report_mismatch($sformatf("item %0d action %0d, want %0d",
                                                  results_seen, o_action, want.act));
                    if (o_egress_port !== want.egress)
                        report_mismatch($sformatf("item %0d egress %0d, want %0d",
                                                  results_seen, o_egress_port, want.egress));
                end
            end
        end
    end

    // frame driver and result receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!push || frame_taken) begin
                if (pending_frames.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    push        <= 1'b1;
                    i_header_ok <= pending_frames[0].hdr_ok;
                    i_src_mac   <= pending_frames[0].src;
                    i_dst_mac   <= pending_frames[0].dst;
                    i_in_port   <= pending_frames[0].port;
                end else begin
                    push <= 1'b0;
                end
            end
            pop <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        bit [47:0] mac_a;
        bit [47:0] mac_b;
        bit [47:0] mac_c;
        bit [47:0] mac_g;
        bit [47:0] mac_pool[POOL_SIZE];
        bit [7:0]  hot_sets[4];
        bit [47:0] src;
        bit [47:0] dst;

        mac_a = 48'h00_11_22_33_44_55;
        mac_b = 48'h02_aa_bb_cc_dd_ee;
        mac_c = 48'h00_00_5e_00_53_01;
        mac_g = 48'h01_00_5e_00_00_fb;

        // bad headers, learning, overwrite, group addresses, extremes
        add_frame(1'b0, '1, '1, 8'd255);
        add_frame(1'b0, '0, '0, 8'd0);
        add_frame(1'b1, mac_a, mac_b, 8'd0);
        add_frame(1'b1, mac_b, mac_a, 8'd255);
        add_frame(1'b1, mac_a, mac_b, 8'd7);
        add_frame(1'b0, mac_c, mac_a, 8'd4);
        add_frame(1'b1, mac_b, mac_c, 8'd12);
        add_frame(1'b1, mac_g, mac_a, 8'd9);
        add_frame(1'b1, mac_a, mac_g, 8'd3);
        add_frame(1'b1, '0, '0, 8'd1);
        add_frame(1'b1, '1, '1, 8'd200);
        // fill one set, refresh its first way, then force an eviction
        for (int k = 1; k <= 4; k++)
            add_frame(1'b1, evict_mac(8'(k)), mac_a, 8'(20 + k));
        add_frame(1'b1, mac_b, evict_mac(8'd1), 8'd30);
        add_frame(1'b1, evict_mac(8'd5), mac_b, 8'd25);
        add_frame(1'b1, mac_a, evict_mac(8'd2), 8'd31);
        add_frame(1'b1, mac_a, evict_mac(8'd5), 8'd32);
        add_frame(1'b1, evict_mac(8'd3), evict_mac(8'd3), 8'd33);

        // address pool crowded into a few sets so that hits and evictions are common
        hot_sets = '{8'h13, 8'h7c, 8'hc5, 8'hff};
        for (int i = 0; i < POOL_SIZE; i++)
            mac_pool[i] = (i % 3 == 0) ? rand_mac() : mac_in_set(hot_sets[i % 4]);
        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            src = ($urandom_range(99) < 85) ? mac_pool[$urandom_range(POOL_SIZE - 1)] : rand_mac();
            dst = ($urandom_range(99) < 85) ? mac_pool[$urandom_range(POOL_SIZE - 1)] : rand_mac();
            add_frame($urandom_range(99) < 92, src, dst, 8'($urandom_range(255)));
        end
        total_frames = pending_frames.size();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_frames.size() != 0 || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
